[rtl/core/tvg_pkg.sv]
// Shared types and constants of the torus vertex generator.
package tvg_pkg;

  // Register indexes of the configuration port
  localparam logic [7:0] REG_MAJOR_RADIUS  = 8'd0;
  localparam logic [7:0] REG_MINOR_RADIUS  = 8'd1;
  localparam logic [7:0] REG_MINOR_DENSITY = 8'd2;
  localparam logic [7:0] REG_MAJOR_DENSITY = 8'd3;

  localparam int ATAN_ENTRIES = 24;
  localparam int DIV_STAGES   = 32;

  // CORDIC gain, Q2.30
  localparam logic [31:0] CORDIC_GAIN = 32'd652032875;

  // atan(2^-i) in 2^-32 turn
  localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic [9:0] ring_index;
    logic [9:0] point_index;
  } tvg_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [19:0]        flat_index;
    logic               index_error;
  } tvg_out_t;

  // Live configuration, densities already limited
  typedef struct packed {
    logic [15:0] major_radius;
    logic [15:0] minor_radius;
    logic [10:0] minor_density;
    logic [10:0] major_density;
  } tvg_cfg_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [9:0]  ring_index;
    logic [9:0]  point_index;
    logic [19:0] flat_index;
    logic        index_error;
  } tvg_item_t;

endpackage

[rtl/core/torus_vertex_generator_core.sv]
// Queue, divider, NCS CORDIC and output stages lead to done; NCS = min(CORDIC_STAGES, 24).
// Throughput: one word a cycle; the divider, CORDIC and multiplier stages are all pipelined.
// busy rises only when the two-word front queue is full, which the back never lets happen.
// Reset: synchronous; registers return to R=1.0, r=0.25, densities 16; pipeline empties.
// The receiver cannot stall: each result shows for one cycle with done.
module torus_vertex_generator_core #(
  parameter int MAX_DENSITY   = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tvg_pkg::tvg_in_t  item,
  output logic              done,
  output tvg_pkg::tvg_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import tvg_pkg::*;

  logic [15:0] major_radius, minor_radius;
  logic [10:0] minor_density, major_density;
  tvg_cfg_t    cfg;
  logic        push, full, not_empty;
  tvg_item_t   push_item, head;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius  <= 16'd256;
      minor_radius  <= 16'd64;
      minor_density <= 11'd16;
      major_density <= 11'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAJOR_RADIUS:  major_radius  <= cfg_data;
        REG_MINOR_RADIUS:  minor_radius  <= cfg_data;
        REG_MINOR_DENSITY: minor_density <= cfg_data[10:0];
        REG_MAJOR_DENSITY: major_density <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // densities limited to the supported maximum
  always_comb begin
    cfg.major_radius  = major_radius;
    cfg.minor_radius  = minor_radius;
    cfg.minor_density = (32'(minor_density) > 32'(MAX_DENSITY)) ?
                        11'(MAX_DENSITY) : minor_density;
    cfg.major_density = (32'(major_density) > 32'(MAX_DENSITY)) ?
                        11'(MAX_DENSITY) : major_density;
  end

  tvg_front u_front (
    .start(start), .busy(full), .item(item), .cfg(cfg),
    .push(push), .push_item(push_item)
  );

  tvg_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(not_empty), .full(full), .not_empty(not_empty), .head(head)
  );

  tvg_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst(rst), .in_valid(not_empty), .in_item(head), .cfg(cfg),
    .done(done), .result(result)
  );
endmodule

[rtl/core/tvg_front.sv]
// Front end: accepts a word, checks indexes and forms the flat position.
module tvg_front (
  input  logic              start,
  input  logic              busy,
  input  tvg_pkg::tvg_in_t  item,
  input  tvg_pkg::tvg_cfg_t cfg,
  output logic              push,
  output tvg_pkg::tvg_item_t push_item
);
  import tvg_pkg::*;

  logic        err;
  logic [20:0] flat;

  assign push = start && !busy;

  // range check and flat position
  always_comb begin
    err  = ({1'b0, item.ring_index} >= cfg.major_density) ||
           ({1'b0, item.point_index} >= cfg.minor_density);
    flat = 21'(item.ring_index * cfg.minor_density) + 21'(item.point_index);
    push_item.ring_index  = item.ring_index;
    push_item.point_index = item.point_index;
    push_item.index_error = err;
    push_item.flat_index  = err ? 20'd0 : flat[19:0];
  end
endmodule

[rtl/core/tvg_queue.sv]
// Two-word queue between front and back.
module tvg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tvg_pkg::tvg_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output tvg_pkg::tvg_item_t head
);
  import tvg_pkg::*;

  tvg_item_t  slot [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/core/tvg_back.sv]
// Back end: phase dividers, two CORDICs and the vertex arithmetic.
module tvg_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tvg_pkg::tvg_item_t in_item,
  input  tvg_pkg::tvg_cfg_t  cfg,
  output logic               done,
  output tvg_pkg::tvg_out_t  result
);
  import tvg_pkg::*;

  localparam int NCS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int CW  = 34;

  typedef struct packed {
    logic [19:0] flat;
    logic        err;
  } tag_t;

  // phase dividers, one quotient bit a stage
  logic [DIV_STAGES:0] dv;
  tag_t        dtag [DIV_STAGES+1];
  logic [10:0] rem_a [DIV_STAGES+1];
  logic [10:0] rem_b [DIV_STAGES+1];
  logic [31:0] q_a   [DIV_STAGES+1];
  logic [31:0] q_b   [DIV_STAGES+1];

  assign dv[0]    = in_valid;
  assign dtag[0]  = '{flat: in_item.flat_index, err: in_item.index_error};
  assign rem_a[0] = {1'b0, in_item.point_index};
  assign rem_b[0] = {1'b0, in_item.ring_index};
  assign q_a[0]   = '0;
  assign q_b[0]   = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [11:0] r2a, r2b;
    logic        gea, geb;
    always_comb begin
      r2a = {rem_a[s], 1'b0};
      r2b = {rem_b[s], 1'b0};
      gea = r2a >= {1'b0, cfg.minor_density};
      geb = r2b >= {1'b0, cfg.major_density};
    end
    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else     dv[s+1] <= dv[s];
    end
    always_ff @(posedge clk) begin
      dtag[s+1]  <= dtag[s];
      rem_a[s+1] <= gea ? 11'(r2a - {1'b0, cfg.minor_density}) : r2a[10:0];
      rem_b[s+1] <= geb ? 11'(r2b - {1'b0, cfg.major_density}) : r2b[10:0];
      q_a[s+1]   <= {q_a[s][30:0], gea};
      q_b[s+1]   <= {q_b[s][30:0], geb};
    end
  end

  // CORDIC rotation, both angles side by side
  logic [NCS:0] cv;
  tag_t                 ctag [NCS+1];
  logic [1:0]           qd_a [NCS+1];
  logic [1:0]           qd_b [NCS+1];
  logic signed [CW-1:0] xa [NCS+1];
  logic signed [CW-1:0] ya [NCS+1];
  logic signed [CW-1:0] za [NCS+1];
  logic signed [CW-1:0] xb [NCS+1];
  logic signed [CW-1:0] yb [NCS+1];
  logic signed [CW-1:0] zb [NCS+1];

  assign cv[0]   = dv[DIV_STAGES];
  assign ctag[0] = dtag[DIV_STAGES];
  assign qd_a[0] = q_a[DIV_STAGES][31:30];
  assign qd_b[0] = q_b[DIV_STAGES][31:30];
  assign xa[0]   = CW'(CORDIC_GAIN);
  assign xb[0]   = CW'(CORDIC_GAIN);
  assign ya[0]   = '0;
  assign yb[0]   = '0;
  assign za[0]   = CW'(q_a[DIV_STAGES][29:0]);
  assign zb[0]   = CW'(q_b[DIV_STAGES][29:0]);

  for (genvar k = 0; k < NCS; k++) begin : g_cordic
    localparam logic signed [CW-1:0] ANG = CW'(ATAN_TURN[k]);
    always_ff @(posedge clk) begin
      if (rst) cv[k+1] <= 1'b0;
      else     cv[k+1] <= cv[k];
    end
    always_ff @(posedge clk) begin
      ctag[k+1] <= ctag[k];
      qd_a[k+1] <= qd_a[k];
      qd_b[k+1] <= qd_b[k];
      if (!za[k][CW-1]) begin
        xa[k+1] <= xa[k] - (ya[k] >>> k);
        ya[k+1] <= ya[k] + (xa[k] >>> k);
        za[k+1] <= za[k] - ANG;
      end else begin
        xa[k+1] <= xa[k] + (ya[k] >>> k);
        ya[k+1] <= ya[k] - (xa[k] >>> k);
        za[k+1] <= za[k] + ANG;
      end
      if (!zb[k][CW-1]) begin
        xb[k+1] <= xb[k] - (yb[k] >>> k);
        yb[k+1] <= yb[k] + (xb[k] >>> k);
        zb[k+1] <= zb[k] - ANG;
      end else begin
        xb[k+1] <= xb[k] + (yb[k] >>> k);
        yb[k+1] <= yb[k] - (xb[k] >>> k);
        zb[k+1] <= zb[k] + ANG;
      end
    end
  end

  // quadrant restore, then the vertex arithmetic
  logic [4:0] mv;
  tag_t mtag [4];
  logic signed [CW-1:0] ca, sa, cb1, sb1, cb2, sb2;
  logic signed [50:0]   pra, prz;
  logic signed [CW-1:0] cb3, sb3;
  logic signed [29:0]   sum;
  logic signed [31:0]   z3, z4;
  logic signed [63:0]   px, py;
  logic signed [51:0]   sum_full, z_full;
  logic signed [63:0]   rx, ry;

  always_comb begin
    sum_full = $signed({6'd0, cfg.major_radius, 30'd0}) + 52'(pra) + 52'sd2097152;
    z_full   = 52'(prz) + 52'sd2097152;
    rx = (px + 64'sd536870912) >>> 30;
    ry = (py + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rst) mv <= '0;
    else     mv <= {mv[3:0], cv[NCS]};
  end

  always_ff @(posedge clk) begin
    mtag[0] <= ctag[NCS];
    for (int i = 1; i < 4; i++) mtag[i] <= mtag[i-1];
    unique case (qd_a[NCS])
      2'd0:    begin ca <= xa[NCS];  sa <= ya[NCS];  end
      2'd1:    begin ca <= -ya[NCS]; sa <= xa[NCS];  end
      2'd2:    begin ca <= -xa[NCS]; sa <= -ya[NCS]; end
      default: begin ca <= ya[NCS];  sa <= -xa[NCS]; end
    endcase
    unique case (qd_b[NCS])
      2'd0:    begin cb1 <= xb[NCS];  sb1 <= yb[NCS];  end
      2'd1:    begin cb1 <= -yb[NCS]; sb1 <= xb[NCS];  end
      2'd2:    begin cb1 <= -xb[NCS]; sb1 <= -yb[NCS]; end
      default: begin cb1 <= yb[NCS];  sb1 <= -xb[NCS]; end
    endcase
    // r times cos and sin of alpha, Q.38
    pra <= 51'($signed({1'b0, cfg.minor_radius}) * ca);
    prz <= 51'($signed({1'b0, cfg.minor_radius}) * sa);
    cb2 <= cb1;
    sb2 <= sb1;
    // rounded to Q.16
    sum <= 30'(sum_full >>> 22);
    z3  <= 32'(z_full >>> 22);
    cb3 <= cb2;
    sb3 <= sb2;
    // sweep products, Q.46
    px <= 64'(sum * cb3);
    py <= 64'(sum * sb3);
    z4 <= z3;
    // rounded result, zeroed on index error
    result.pos_x       <= mtag[3].err ? 32'sd0 : 32'(rx);
    result.pos_y       <= mtag[3].err ? 32'sd0 : 32'(ry);
    result.pos_z       <= mtag[3].err ? 32'sd0 : z4;
    result.flat_index  <= mtag[3].flat;
    result.index_error <= mtag[3].err;
  end

  assign done = mv[4];
endmodule
